/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define SLC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// expression must never be true outside reset
`define SLC_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define SLC_ASSERT(lbl, clk, rst_n, prop)
`define SLC_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* src/slc_pkg.sv */
// ---------------------------------------------------------------------------
// slc_pkg
// types, constants and helpers for the hex record loader
// ---------------------------------------------------------------------------
package slc_pkg;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_S  = 8'h53;
    localparam logic [7:0] CHAR_9  = 8'h39;

    localparam int unsigned POS_W = 10;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_WRITE   = 3'd0,
        KIND_GOOD    = 3'd1,
        KIND_BAD_SUM = 3'd2,
        KIND_END     = 3'd3,
        KIND_FORMAT  = 3'd4
    } t_kind;

    // one classified action handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [15:0] base_addr;
        logic [7:0]  offset;
        logic [7:0]  data;
        logic [7:0]  csum;
        logic [7:0]  given;
    } t_cmd;

    // {valid, value} of one hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = '0;
        if (c inside {[8'h30:8'h39]}) begin
            res = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h41:8'h46]}) begin
            res = {1'b1, 4'(c - 8'h37)};
        end else if (c inside {[8'h61:8'h66]}) begin
            res = {1'b1, 4'(c - 8'h57)};
        end
        return res;
    endfunction

endpackage

/* src/slc_char_if.sv */
// ---------------------------------------------------------------------------
// slc_char_if
// character stream channel, one character per word
// ---------------------------------------------------------------------------
interface slc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;

    modport source (output valid, output text_char, input ready);
    modport sink   (input valid, input text_char, output ready);
endinterface

/* src/slc_result_if.sv */
// ---------------------------------------------------------------------------
// slc_result_if
// result channel: memory writes and record status
// ---------------------------------------------------------------------------
interface slc_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [7:0]  computed_sum;
    logic [7:0]  given_sum;

    modport source (output valid, output kind, output write_address,
                    output write_data, output computed_sum, output given_sum,
                    input ready);
    modport sink   (input valid, input kind, input write_address,
                    input write_data, input computed_sum, input given_sum,
                    output ready);
endinterface

/* src/slc_front.sv */
// ---------------------------------------------------------------------------
// slc_front
// record parser: tracks line position, decodes fields, classifies actions
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slc_char_if.sink      i_char,
    input  logic          i_q_full,
    output logic          o_push,
    output slc_pkg::t_cmd o_cmd
);

    logic [slc_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_offset, n_offset;
    logic [7:0]  r_sum, n_sum;
    logic [3:0]  r_high, n_high;
    logic        r_saw_s, n_saw_s;
    logic        r_halted, n_halted;

    logic                      accept;
    logic [4:0]                hex;
    logic [7:0]                byte_val;
    logic [7:0]                n_data;
    logic [slc_pkg::POS_W-1:0] pos_m2;
    logic [slc_pkg::POS_W-2:0] byte_idx;
    logic [slc_pkg::POS_W-2:0] last_idx;

    assign i_char.ready = !i_q_full;
    assign accept       = i_char.valid && i_char.ready;
    assign hex          = slc_pkg::hex_decode(i_char.text_char);
    assign byte_val     = {r_high, hex[3:0]};
    assign n_data       = (r_count > 8'd3) ? r_count - 8'd3 : 8'd0;
    assign pos_m2       = r_pos - 10'd2;
    assign byte_idx     = pos_m2[slc_pkg::POS_W-1:1];
    assign last_idx     = 9'd3 + {1'b0, n_data};

    always_comb begin
        n_pos    = r_pos;
        n_count  = r_count;
        n_addr   = r_addr;
        n_offset = r_offset;
        n_sum    = r_sum;
        n_high   = r_high;
        n_saw_s  = r_saw_s;
        n_halted = r_halted;
        o_push   = 1'b0;
        o_cmd    = '0;
        if (accept && !r_halted) begin
            if (i_char.text_char == slc_pkg::CHAR_LF) begin
                n_pos   = '0;
                n_saw_s = 1'b0;
            end else begin
                if (r_pos != slc_pkg::POS_MAX) begin
                    n_pos = r_pos + 10'd1;
                end
                if (r_pos == 10'd0) begin
                    n_saw_s = (i_char.text_char == slc_pkg::CHAR_S);
                end else if (r_pos == 10'd1) begin
                    if (r_saw_s && i_char.text_char == slc_pkg::CHAR_9) begin
                        n_halted   = 1'b1;
                        o_push     = 1'b1;
                        o_cmd.kind = slc_pkg::KIND_END;
                    end
                end else if (byte_idx <= last_idx) begin
                    if (!hex[4]) begin
                        n_halted   = 1'b1;
                        o_push     = 1'b1;
                        o_cmd.kind = slc_pkg::KIND_FORMAT;
                    end else if (!r_pos[0]) begin
                        n_high = hex[3:0];
                    end else if (byte_idx == 9'd0) begin
                        n_count = byte_val;
                        n_sum   = byte_val;
                    end else if (byte_idx == 9'd1) begin
                        n_addr = {byte_val, 8'h00};
                        n_sum  = r_sum + byte_val;
                    end else if (byte_idx == 9'd2) begin
                        n_addr   = {r_addr[15:8], byte_val};
                        n_sum    = r_sum + byte_val;
                        n_offset = '0;
                    end else if (byte_idx < last_idx) begin
                        o_push          = 1'b1;
                        o_cmd.kind      = slc_pkg::KIND_WRITE;
                        o_cmd.base_addr = r_addr;
                        o_cmd.offset    = r_offset;
                        o_cmd.data      = byte_val;
                        n_offset        = r_offset + 8'd1;
                        n_sum           = r_sum + byte_val;
                    end else begin
                        o_push      = 1'b1;
                        o_cmd.csum  = r_sum;
                        o_cmd.given = byte_val;
                        if (({1'b0, r_sum} + {1'b0, byte_val}) == 9'd255) begin
                            o_cmd.kind = slc_pkg::KIND_GOOD;
                        end else begin
                            o_cmd.kind = slc_pkg::KIND_BAD_SUM;
                            n_halted   = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_count  <= '0;
            r_addr   <= '0;
            r_offset <= '0;
            r_sum    <= '0;
            r_high   <= '0;
            r_saw_s  <= 1'b0;
            r_halted <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_addr   <= n_addr;
            r_offset <= n_offset;
            r_sum    <= n_sum;
            r_high   <= n_high;
            r_saw_s  <= n_saw_s;
            r_halted <= n_halted;
        end
    end

    // halt is sticky until reset
    `SLC_ASSERT(a_halt_sticky, i_clk, i_rst_n, r_halted |=> r_halted)
    // nothing is classified once halted
    `SLC_NEVER(a_no_push_halted, i_clk, i_rst_n, o_push && r_halted)
    // terminal kinds always halt the parser
    `SLC_ASSERT(a_term_halts, i_clk, i_rst_n,
        (o_push && (o_cmd.kind == slc_pkg::KIND_END ||
        o_cmd.kind == slc_pkg::KIND_FORMAT || o_cmd.kind == slc_pkg::KIND_BAD_SUM))
        |=> r_halted)

endmodule

/* src/slc_queue.sv */
// ---------------------------------------------------------------------------
// slc_queue
// short action queue between parser and output stage
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  slc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output slc_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    slc_pkg::t_cmd r_mem [slc_pkg::Q_DEPTH];
    logic [slc_pkg::Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [slc_pkg::Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [slc_pkg::Q_CNT_W-1:0] r_count, n_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == slc_pkg::Q_CNT_W'(slc_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == slc_pkg::Q_PTR_W'(slc_pkg::Q_DEPTH - 1))
                       ? '0 : r_wr_ptr + slc_pkg::Q_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == slc_pkg::Q_PTR_W'(slc_pkg::Q_DEPTH - 1))
                       ? '0 : r_rd_ptr + slc_pkg::Q_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + slc_pkg::Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - slc_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `SLC_ASSERT(a_cnt_range, i_clk, i_rst_n,
        r_count <= slc_pkg::Q_CNT_W'(slc_pkg::Q_DEPTH))
    // a word offered to a full queue would be lost
    `SLC_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full)
    // pointers agree with the fill level
    `SLC_ASSERT(a_ptr_match, i_clk, i_rst_n,
        (r_count == '0 || o_full) |-> (r_wr_ptr == r_rd_ptr))

endmodule

/* src/slc_back.sv */
// ---------------------------------------------------------------------------
// slc_back
// output stage: forms the write address and holds the result word
// ---------------------------------------------------------------------------
module slc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  slc_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    slc_result_if.source  o_result
);

    logic        r_valid, n_valid;
    logic [2:0]  r_kind;
    logic [15:0] r_addr;
    logic [7:0]  r_data;
    logic [7:0]  r_csum;
    logic [7:0]  r_given;

    assign o_pop   = !i_empty && (!r_valid || o_result.ready);
    assign n_valid = o_pop || (r_valid && !o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind  <= i_cmd.kind;
            r_addr  <= i_cmd.base_addr + {8'h00, i_cmd.offset};
            r_data  <= i_cmd.data;
            r_csum  <= i_cmd.csum;
            r_given <= i_cmd.given;
        end
    end

    assign o_result.valid         = r_valid;
    assign o_result.kind          = r_kind;
    assign o_result.write_address = r_addr;
    assign o_result.write_data    = r_data;
    assign o_result.computed_sum  = r_csum;
    assign o_result.given_sum     = r_given;

endmodule

/* src/srecord_loader_checksum_core.sv */
// result words pass from the parser through the queue into the output register
// throughput: one character per cycle, held off only while the result side stalls
// the two-entry action queue and the output register absorb a stalled result side
// reset: synchronous active-low, clears the parser and queue; no memory clearing pass
// ---------------------------------------------------------------------------
// srecord_loader_checksum_core
// hex record loader: parses S1 records into memory writes with checksum check
// ---------------------------------------------------------------------------
module srecord_loader_checksum_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slc_char_if.sink     i_char,
    slc_result_if.source o_result
);

    // parser -> queue
    logic          push;
    slc_pkg::t_cmd push_cmd;
    // queue -> output stage
    slc_pkg::t_cmd head_cmd;
    logic          q_full;
    logic          q_empty;
    logic          pop;

    // front: walks each line, decodes count, address, data and checksum,
    // keeps the running sum and decides the kind of each result word.
    // it only stalls when the queue is full
    slc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (i_char),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // short queue so the parser keeps going while a result word waits
    slc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: adds record address and data offset (16-bit wrap) and
    // registers the result word toward the sink
    slc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
